/* src/ppmfd_pkg.sv */
// Shared types and constants of the PPM frame decoder.
package ppmfd_pkg;

    localparam int DATA_W     = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int PADDR_W    = 3;

    // Register index, taken from the word address bit of paddr.
    typedef enum logic {
        REG_SYNC_THRESHOLD = 1'b0
    } reg_index_t;

    localparam logic [DATA_W-1:0] SYNC_RESET_US = 32'd2100;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified interval, handed from the front end to the back end.
    typedef struct packed {
        logic [DATA_W-1:0] interval_us;
        logic              sync;
    } interval_item_t;

endpackage

/* src/ppmfd_front.sv */
// Front end: accept capture words, convert to microseconds, classify intervals.
module ppmfd_front #(
    parameter int unsigned CLOCKS_PER_US = 100
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ppmfd_pkg::DATA_W-1:0]  s_capture_count,
    input  logic [ppmfd_pkg::DATA_W-1:0]  sync_threshold_us,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ppmfd_pkg::interval_item_t     push_item
);

    // Exact reciprocal: q = (x * RECIP) >> SHIFT for every 32-bit x.
    localparam int FRAC_W = $clog2(CLOCKS_PER_US);
    localparam int SHIFT  = ppmfd_pkg::DATA_W + FRAC_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(CLOCKS_PER_US) - 64'd1) / 64'(CLOCKS_PER_US);
    localparam int RECIP_W = ppmfd_pkg::DATA_W + 1;
    localparam int PROD_W  = ppmfd_pkg::DATA_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic                          prod_valid_reg;
    logic                          prod_valid_next;
    logic [PROD_W-1:0]             prod_reg;
    logic [PROD_W-1:0]             prod_next;
    logic [ppmfd_pkg::DATA_W-1:0]  prev_time_reg;
    logic [ppmfd_pkg::DATA_W-1:0]  prev_time_next;
    logic [PROD_W-1:0]             quot_full;
    logic [ppmfd_pkg::DATA_W-1:0]  now_us;
    logic [ppmfd_pkg::DATA_W-1:0]  interval_us;
    logic                          accept;
    logic                          push;

    assign push    = prod_valid_reg && push_ready;
    assign s_ready = !prod_valid_reg || push_ready;
    assign accept  = s_valid && s_ready;

    assign quot_full   = prod_reg >> SHIFT;
    assign now_us      = quot_full[ppmfd_pkg::DATA_W-1:0];
    assign interval_us = now_us - prev_time_reg;

    assign push_valid            = prod_valid_reg;
    assign push_item.interval_us = interval_us;
    assign push_item.sync        = interval_us > sync_threshold_us;

    always_comb begin
        prod_next       = prod_reg;
        prod_valid_next = prod_valid_reg;
        prev_time_next  = prev_time_reg;
        if (push) begin
            prod_valid_next = 1'b0;
            prev_time_next  = now_us;
        end
        if (accept) begin
            prod_valid_next = 1'b1;
            prod_next       = PROD_W'(s_capture_count) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            prev_time_reg  <= '0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            prev_time_reg  <= prev_time_next;
        end
        prod_reg <= prod_next;
    end

endmodule

/* src/ppmfd_queue.sv */
// Short queue between the front end and the back end.
module ppmfd_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push_valid,
    output logic                      push_ready,
    input  ppmfd_pkg::interval_item_t push_item,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output ppmfd_pkg::interval_item_t pop_item
);

    ppmfd_pkg::interval_item_t             entry_reg [ppmfd_pkg::QUEUE_DEPTH];
    logic [ppmfd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [ppmfd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [ppmfd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [ppmfd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [ppmfd_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [ppmfd_pkg::QUEUE_CNT_W-1:0]     count_next;
    logic                                  push;
    logic                                  pop;

    assign push_ready = count_reg != ppmfd_pkg::QUEUE_CNT_W'(ppmfd_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == ppmfd_pkg::QUEUE_PTR_W'(ppmfd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == ppmfd_pkg::QUEUE_PTR_W'(ppmfd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ppmfd_pkg::QUEUE_CNT_W'(ppmfd_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* src/ppmfd_back.sv */
// Back end: slot sequencing, channel store and the result register.
module ppmfd_back #(
    parameter int unsigned NUM_CHANNELS = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  ppmfd_pkg::interval_item_t        pop_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ppmfd_pkg::SLOT_OUT_W-1:0] m_slot_written,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_interval_us,
    output logic                             m_sync_seen,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_roll_us,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_pitch_us,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_throttle_us,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_yaw_us
);

    localparam int SLOT_W = $clog2(NUM_CHANNELS);

    logic [ppmfd_pkg::DATA_W-1:0]     chan_reg  [NUM_CHANNELS];
    logic [ppmfd_pkg::DATA_W-1:0]     chan_next [NUM_CHANNELS];
    logic [SLOT_W-1:0]                next_slot_reg;
    logic [SLOT_W-1:0]                next_slot_next;
    logic [SLOT_W-1:0]                slot;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [ppmfd_pkg::SLOT_OUT_W-1:0] slot_out_reg;
    logic [ppmfd_pkg::DATA_W-1:0]     interval_out_reg;
    logic                             sync_out_reg;
    logic [ppmfd_pkg::DATA_W-1:0]     roll_out_reg;
    logic [ppmfd_pkg::DATA_W-1:0]     pitch_out_reg;
    logic [ppmfd_pkg::DATA_W-1:0]     throttle_out_reg;
    logic [ppmfd_pkg::DATA_W-1:0]     yaw_out_reg;
    logic                             pop;

    assign pop_ready = !out_valid_reg || m_ready;
    assign pop       = pop_valid && pop_ready;
    assign slot      = pop_item.sync ? '0 : next_slot_reg;

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_next[i] = chan_reg[i];
            if (pop && slot == SLOT_W'(i)) begin
                chan_next[i] = pop_item.interval_us;
            end
        end
        next_slot_next = next_slot_reg;
        if (pop) begin
            next_slot_next = (slot == SLOT_W'(NUM_CHANNELS - 1)) ? '0 : slot + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            next_slot_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_reg[i] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            next_slot_reg <= next_slot_next;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_reg[i] <= chan_next[i];
            end
        end
        if (pop) begin
            slot_out_reg     <= ppmfd_pkg::SLOT_OUT_W'(slot);
            interval_out_reg <= pop_item.interval_us;
            sync_out_reg     <= pop_item.sync;
            roll_out_reg     <= chan_next[1];
            pitch_out_reg    <= chan_next[2];
            throttle_out_reg <= chan_next[3];
            yaw_out_reg      <= chan_next[4];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_slot_written = slot_out_reg;
    assign m_interval_us  = interval_out_reg;
    assign m_sync_seen    = sync_out_reg;
    assign m_roll_us      = roll_out_reg;
    assign m_pitch_us     = pitch_out_reg;
    assign m_throttle_us  = throttle_out_reg;
    assign m_yaw_us       = yaw_out_reg;

`ifndef NO_ASSERTIONS
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        next_slot_reg <= SLOT_W'(NUM_CHANNELS - 1))
        else $error("next slot out of range");
    a_sync_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && sync_out_reg |-> slot_out_reg == '0)
        else $error("sync interval not in slot zero");
    a_sync_then_one: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && pop_item.sync |=> next_slot_reg == SLOT_W'(1))
        else $error("slot after sync is not one");
`endif

endmodule

/* src/ppm_frame_decoder.sv */
// PPM frame decoder (top level): APB register, front end, queue and back end.
//
// Each word on the s_ channel is a timer capture taken at a PPM edge. The
// front end turns it into whole microseconds (count / CLOCKS_PER_US, exact,
// through a registered reciprocal multiply). It subtracts the previous time
// with 32-bit wrap and flags frame sync when the interval is strictly above
// sync_threshold_us (APB offset 0x0, reset 2100). The back end stores the
// interval in slot 0 on sync, else in the running slot, which wraps at
// NUM_CHANNELS. It returns one word per capture with the slot, interval,
// sync flag and channels 1 to 4 after the update. Throughput is one word per
// clock while neither side stalls. Each accepted capture is registered in
// the reciprocal multiply register, then in the two-entry queue and then in
// the result register. Either side may stall independently; the queue
// absorbs the difference. Write the threshold only while no capture is in
// flight.
module ppm_frame_decoder #(
    parameter int unsigned NUM_CHANNELS  = 9,
    parameter int unsigned CLOCKS_PER_US = 100
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppmfd_pkg::PADDR_W-1:0]    paddr,
    input  logic [ppmfd_pkg::DATA_W-1:0]     pwdata,
    output logic [ppmfd_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ppmfd_pkg::DATA_W-1:0]     s_capture_count,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ppmfd_pkg::SLOT_OUT_W-1:0] m_slot_written,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_interval_us,
    output logic                             m_sync_seen,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_roll_us,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_pitch_us,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_throttle_us,
    output logic [ppmfd_pkg::DATA_W-1:0]     m_yaw_us
);

    logic [ppmfd_pkg::DATA_W-1:0] sync_thr_reg;
    logic [ppmfd_pkg::DATA_W-1:0] sync_thr_next;
    ppmfd_pkg::reg_index_t        reg_index;
    logic                         reg_write;
    logic                         push_valid;
    logic                         push_ready;
    ppmfd_pkg::interval_item_t    push_item;
    logic                         pop_valid;
    logic                         pop_ready;
    ppmfd_pkg::interval_item_t    pop_item;

    // Decode on the word address bit; byte offset bits are ignored.
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_comb begin
        reg_index     = ppmfd_pkg::reg_index_t'(paddr[2]);
        sync_thr_next = sync_thr_reg;
        prdata        = '0;
        case (reg_index)
            ppmfd_pkg::REG_SYNC_THRESHOLD: begin
                prdata = sync_thr_reg;
                if (reg_write) begin
                    sync_thr_next = pwdata;
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_thr_reg <= ppmfd_pkg::SYNC_RESET_US;
        end else begin
            sync_thr_reg <= sync_thr_next;
        end
    end

    // Convert, difference and classify each capture word.
    ppmfd_front #(
        .CLOCKS_PER_US(CLOCKS_PER_US)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_capture_count  (s_capture_count),
        .sync_threshold_us(sync_thr_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item)
    );

    // Hold classified intervals while the result side stalls.
    ppmfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    // Advance the slot, update the channel store and register the result.
    ppmfd_back #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot_written(m_slot_written),
        .m_interval_us (m_interval_us),
        .m_sync_seen   (m_sync_seen),
        .m_roll_us     (m_roll_us),
        .m_pitch_us    (m_pitch_us),
        .m_throttle_us (m_throttle_us),
        .m_yaw_us      (m_yaw_us)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the PPM frame decoder: directed edge cases, then random frames.
`timescale 1ns / 1ps

module tb;

    // Build of the block under test; the predictor uses the same numbers.
    localparam int unsigned NUM_CHANNELS  = 9;
    localparam int unsigned CLOCKS_PER_US = 100;

    // Register map: one 32-bit register per word. The spare address decodes to
    // an index past the map, and a write there must leave the threshold alone.
    localparam logic [ppmfd_pkg::PADDR_W-1:0] THRESH_ADDR =
        ppmfd_pkg::PADDR_W'(ppmfd_pkg::REG_SYNC_THRESHOLD) << 2;
    localparam logic [ppmfd_pkg::PADDR_W-1:0] SPARE_ADDR  =
        THRESH_ADDR + ppmfd_pkg::PADDR_W'(4);

    // Idle margin before touching the register and at the end of the run.
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    // One decoded word as the result channel should present it.
    typedef struct {
        logic [ppmfd_pkg::SLOT_OUT_W-1:0] slot;
        logic [ppmfd_pkg::DATA_W-1:0]     interval;
        logic                             sync;
        logic [ppmfd_pkg::DATA_W-1:0]     roll;
        logic [ppmfd_pkg::DATA_W-1:0]     pitch;
        logic [ppmfd_pkg::DATA_W-1:0]     throttle;
        logic [ppmfd_pkg::DATA_W-1:0]     yaw;
    } frame_word_t;

    logic                             aclk            = 1'b0;
    logic                             aresetn         = 1'b0;
    logic                             psel            = 1'b0;
    logic                             penable         = 1'b0;
    logic                             pwrite          = 1'b0;
    logic [ppmfd_pkg::PADDR_W-1:0]    paddr           = '0;
    logic [ppmfd_pkg::DATA_W-1:0]     pwdata          = '0;
    logic [ppmfd_pkg::DATA_W-1:0]     prdata;
    logic                             pready;
    logic                             s_valid         = 1'b0;
    logic                             s_ready;
    logic [ppmfd_pkg::DATA_W-1:0]     s_capture_count = '0;
    logic                             m_valid;
    logic                             m_ready         = 1'b0;
    logic [ppmfd_pkg::SLOT_OUT_W-1:0] m_slot_written;
    logic [ppmfd_pkg::DATA_W-1:0]     m_interval_us;
    logic                             m_sync_seen;
    logic [ppmfd_pkg::DATA_W-1:0]     m_roll_us;
    logic [ppmfd_pkg::DATA_W-1:0]     m_pitch_us;
    logic [ppmfd_pkg::DATA_W-1:0]     m_throttle_us;
    logic [ppmfd_pkg::DATA_W-1:0]     m_yaw_us;

    // Decoder state as the block should hold it.
    logic [ppmfd_pkg::DATA_W-1:0]     prev_time_us;
    logic [3:0]                       slot_cursor;
    logic [ppmfd_pkg::DATA_W-1:0]     channel_us [NUM_CHANNELS];
    logic [ppmfd_pkg::DATA_W-1:0]     sync_threshold_cfg;

    frame_word_t                      pending_words [$];
    logic [ppmfd_pkg::DATA_W-1:0]     last_count = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;
    int error_count   = 0;
    int words_in      = 0;
    int words_out     = 0;
    int syncs_out     = 0;
    int thresholds    = 1;

    ppm_frame_decoder #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .CLOCKS_PER_US (CLOCKS_PER_US)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_capture_count (s_capture_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_written  (m_slot_written),
        .m_interval_us   (m_interval_us),
        .m_sync_seen     (m_sync_seen),
        .m_roll_us       (m_roll_us),
        .m_pitch_us      (m_pitch_us),
        .m_throttle_us   (m_throttle_us),
        .m_yaw_us        (m_yaw_us)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return the decoder to its post-reset state: time zero, slot zero,
    // every channel cleared and the threshold at its reset value.
    task automatic clear_decoder_state();
        prev_time_us       = '0;
        slot_cursor        = '0;
        sync_threshold_cfg = ppmfd_pkg::SYNC_RESET_US;
        foreach (channel_us[i]) channel_us[i] = '0;
    endtask

    // Decode one capture: convert to whole microseconds, take the wrapping
    // difference, classify it and file it into its slot.
    function automatic frame_word_t decode_capture(input logic [ppmfd_pkg::DATA_W-1:0] count);
        frame_word_t                  w;
        logic [ppmfd_pkg::DATA_W-1:0] now_us;
        logic [3:0]                   slot;
        now_us     = count / CLOCKS_PER_US;
        w.interval = now_us - prev_time_us;
        // Strictly above: an interval equal to the threshold is a channel.
        w.sync     = w.interval > sync_threshold_cfg;
        prev_time_us = now_us;
        if (w.sync) begin
            slot = '0;
        end else begin
            slot = 4'(slot_cursor % NUM_CHANNELS);
        end
        channel_us[slot] = w.interval;
        slot_cursor      = 4'((slot + 1) % NUM_CHANNELS);
        w.slot     = ppmfd_pkg::SLOT_OUT_W'(slot);
        w.roll     = channel_us[1];
        w.pitch    = channel_us[2];
        w.throttle = channel_us[3];
        w.yaw      = channel_us[4];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one capture word, idling first at the sender's rate, and file
    // its expected result once the block takes it.
    task automatic send_capture(input logic [ppmfd_pkg::DATA_W-1:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_capture_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_words.push_back(decode_capture(count));
        last_count = count;
        words_in++;
    endtask

    // Capture at an absolute time; the sub-microsecond part is random so the
    // low bits of the count keep moving without changing the decoded time.
    task automatic send_at_us(input int unsigned us);
        send_capture(ppmfd_pkg::DATA_W'(us * CLOCKS_PER_US
                                        + $urandom_range(CLOCKS_PER_US - 1)));
    endtask

    // Capture a given number of microseconds after the previous one.
    task automatic send_after_us(input int unsigned us);
        send_capture(last_count + ppmfd_pkg::DATA_W'(us * CLOCKS_PER_US));
    endtask

    // Drop valid and hold until every expected word is back and the
    // pipeline has had time to empty.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic apb_write(input logic [ppmfd_pkg::PADDR_W-1:0] addr,
                             input logic [ppmfd_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Only the threshold word is mapped; anything past it is ignored.
        if (addr[ppmfd_pkg::PADDR_W-1:2] == ppmfd_pkg::REG_SYNC_THRESHOLD)
            sync_threshold_cfg = data;
    endtask

    task automatic set_threshold(input logic [ppmfd_pkg::DATA_W-1:0] value);
        wait_drained();
        apb_write(THRESH_ADDR, value);
        thresholds++;
    endtask

    // Receiver: stall at the current rate, ready otherwise.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field,
                                   input logic [ppmfd_pkg::DATA_W-1:0] want,
                                   input logic [ppmfd_pkg::DATA_W-1:0] got);
        if (error_count < MAX_REPORTS) begin
            $display("%0t: word %0d %s expected 0x%08h got 0x%08h",
                     $realtime, words_out, field, want, got);
        end
        error_count++;
    endtask

    // Compare each returned word with the oldest expectation, field by field.
    always @(posedge aclk) begin
        frame_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", '0, m_interval_us);
            end else begin
                want = pending_words.pop_front();
                if (m_slot_written !== want.slot)
                    report_mismatch("slot_written", ppmfd_pkg::DATA_W'(want.slot),
                                    ppmfd_pkg::DATA_W'(m_slot_written));
                if (m_interval_us !== want.interval)
                    report_mismatch("interval_us", want.interval, m_interval_us);
                if (m_sync_seen !== want.sync)
                    report_mismatch("sync_seen", ppmfd_pkg::DATA_W'(want.sync),
                                    ppmfd_pkg::DATA_W'(m_sync_seen));
                if (m_roll_us !== want.roll)
                    report_mismatch("roll_us", want.roll, m_roll_us);
                if (m_pitch_us !== want.pitch)
                    report_mismatch("pitch_us", want.pitch, m_pitch_us);
                if (m_throttle_us !== want.throttle)
                    report_mismatch("throttle_us", want.throttle, m_throttle_us);
                if (m_yaw_us !== want.yaw)
                    report_mismatch("yaw_us", want.yaw, m_yaw_us);
                if (want.sync) syncs_out++;
            end
            words_out++;
        end
    end

    // Watchdog: count cycles in which nothing moves on any port.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no word moved for %0d cycles, %0d still expected",
                 WATCHDOG_LIMIT, pending_words.size());
        $display("[ppm_frame_decoder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First edge after reset is measured from time zero and, being short,
    // lands in slot zero as a channel. Then hit both count extremes.
    task automatic test_first_edge();
        send_at_us(1500);
        send_capture('0);
        send_capture('1);
    endtask

    // Counter rollover between two captures.
    task automatic test_time_wrap();
        send_capture(32'hFFFF_FF00);
        send_capture(32'h0000_0F00);
    endtask

    // Interval on the threshold is a channel, one above is a sync; then the
    // register extremes: zero makes any non-zero gap a sync, all ones none.
    task automatic test_threshold_edges();
        send_at_us(10000);
        send_at_us(10000 + ppmfd_pkg::SYNC_RESET_US);
        send_at_us(10000 + 2 * ppmfd_pkg::SYNC_RESET_US + 1);
        set_threshold('0);
        send_after_us(0);
        send_after_us(1);
        set_threshold('1);
        send_capture('0);
        send_capture('1);
    endtask

    // One sync, then more channels than slots so the cursor wraps to zero
    // without a sync in between.
    task automatic test_slot_wrap();
        set_threshold(ppmfd_pkg::SYNC_RESET_US);
        send_after_us(5000);
        for (int k = 0; k < NUM_CHANNELS + 1; k++) send_after_us(1000 + 100 * k);
    endtask

    // A write past the register map must not reach the threshold: with all
    // ones there, the gap below would stop being a sync.
    task automatic test_register_decode();
        wait_drained();
        apb_write(SPARE_ADDR, '1);
        send_after_us(3000);
    endtask

    // Mostly well-formed frames (sync gap plus a run of channel pulses, some
    // frames short, some long enough to wrap the slot), with random captures,
    // repeated captures and gaps exactly on the threshold mixed in.
    task automatic test_random_frames(input int send_pct, input int recv_pct,
                                      input logic [ppmfd_pkg::DATA_W-1:0] threshold,
                                      input int n_items);
        int sent;
        int pick;
        int chans;
        set_threshold(threshold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_after_us(sync_threshold_cfg + $urandom_range(1, 15000));
                chans = $urandom_range(NUM_CHANNELS - 4, NUM_CHANNELS + 2);
                for (int k = 0; k < chans; k++) send_after_us($urandom_range(900, 2200));
                sent += chans + 1;
            end else if (pick < 92) begin
                send_capture($urandom());
                sent++;
            end else begin
                send_capture(last_count);
                send_after_us(sync_threshold_cfg);
                sent += 2;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_decoder_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases run under the first idling pattern.
        send_idle_pct = 9;
        recv_idle_pct = 69;
        test_first_edge();
        test_time_wrap();
        test_threshold_edges();
        test_slot_wrap();
        test_register_decode();

        test_random_frames(9, 69, ppmfd_pkg::SYNC_RESET_US, 300);
        test_random_frames(69, 9, $urandom_range(1500, 4000), 300);
        test_random_frames(0, 0, $urandom_range(1000, 3000), 300);
        wait_drained();

        $display("covered %0d captures and %0d decoded words (%0d frame syncs)",
                 words_in, words_out, syncs_out);
        $display("over %0d threshold settings and three stall patterns, %0d mismatches",
                 thresholds, error_count);
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("[ppm_frame_decoder] OK");
        end else begin
            $display("[ppm_frame_decoder] ERROR");
        end
        $finish;
    end

endmodule
